[design/bfha_pkg.sv]
// ----------------------------------------------------------------------------
// bfha_pkg
// Codes and fixed constants of the best-fit heap allocator.
// ----------------------------------------------------------------------------
package bfha_pkg;

  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_REINIT  = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
  localparam logic [2:0] ST_NO_FIT    = 3'd2;
  localparam logic [2:0] ST_NOT_ALLOC = 3'd3;
  localparam logic [2:0] ST_LIST_FULL = 3'd4;

  localparam logic [1:0] MK_NONE  = 2'd0;
  localparam logic [1:0] MK_ALLOC = 2'd1;
  localparam logic [1:0] MK_FREE  = 2'd2;

  localparam int HEAP_FLOOR = 4096;
  localparam int MIN_SPLIT  = 32;
  localparam int HDR_BYTES  = 8;
  localparam int MSZ_W      = 15;
  localparam int MARK_W     = MSZ_W + 2;

endpackage

[design/bfha_ram.sv]
// ----------------------------------------------------------------------------
// bfha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/best_fit_heap_allocator_unit.sv]
// ----------------------------------------------------------------------------
// best_fit_heap_allocator_unit
// Best-fit heap allocator with an address-sorted free list and coalescing.
//
//   channel | dir | fields (low bit up)
//   in_     | in  | tuser: kind; tdata: alloc_size, release_offset
//   out_    | out | tdata: status, data_offset, free_chunks
//   cfg_    | in  | wdata: heap_size
//
// Allocate scans the whole free list, then shifts the list down after a
// whole-chunk take; release checks the mark RAM, scans the list and may
// shift it; one free list RAM port pair walks the list one entry a cycle.
// Reinitialize and reset sweep the mark RAM with in_tready low. A result
// waiting on out_tready holds the next item in its final state.
// ----------------------------------------------------------------------------
module best_fit_heap_allocator_unit
  import bfha_pkg::*;
#(
  parameter int MAX_HEAP_BYTES  = 16384,
  parameter int FREE_LIST_DEPTH = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // alloc_size[15:0], release_offset[29:16]
  input  logic [1:0]  in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // status[2:0], data_offset[16:3], free_chunks[26:17]
  input  logic        cfg_wen,
  input  logic [14:0] cfg_wdata   // heap_size
);

  localparam int AW         = $clog2(MAX_HEAP_BYTES + 1);
  localparam int CW         = (AW > 17) ? AW : 17;
  localparam int MARK_DEPTH = MAX_HEAP_BYTES / 4;
  localparam int MW         = $clog2(MARK_DEPTH);
  localparam int LW         = $clog2(FREE_LIST_DEPTH);
  localparam int CNTW       = $clog2(FREE_LIST_DEPTH + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RCHK, S_MCHK, S_SCAN, S_DECIDE, S_SHIFT, S_FIX, S_REPLY
  } state_t;

  state_t              state_r;
  logic [14:0]         heap_size_r;
  logic [AW-1:0]       heap_bytes_r;
  logic [CNTW-1:0]     list_cap_r;
  logic [CNTW-1:0]     count_r;
  logic [MW-1:0]       clr_r;
  logic                clr_reply_r;
  logic                is_rel_r;
  logic                rel_lo_r;
  logic [CW-1:0]       need_r;
  logic [CW-1:0]       hdr_r;
  logic [MSZ_W-1:0]    rsz_r;
  logic [CNTW-1:0]     sc_r;
  logic                pend_r;
  logic [CNTW-1:0]     pidx_r;
  logic                found_r;
  logic [CNTW-1:0]     best_idx_r;
  logic [AW-1:0]       best_off_r;
  logic [AW-1:0]       best_sz_r;
  logic [CNTW-1:0]     pos_r;
  logic                have_prev_r;
  logic [AW-1:0]       prev_off_r;
  logic [AW-1:0]       prev_sz_r;
  logic                have_next_r;
  logic [AW-1:0]       next_off_r;
  logic [AW-1:0]       next_sz_r;
  logic [CNTW-1:0]     sh_cur_r;
  logic [CNTW-1:0]     sh_end_r;
  logic                sh_up_r;
  logic                sh_done_r;
  logic                fix_en_r;
  logic [CNTW-1:0]     fix_addr_r;
  logic [2*AW-1:0]     fix_data_r;
  logic                mk_en_r;
  logic [MW-1:0]       mk_addr_r;
  logic [MARK_W-1:0]   mk_data_r;
  logic [CNTW-1:0]     cnt_new_r;
  logic [2:0]          st_r;
  logic [13:0]         dout_r;
  logic                out_tvalid_r;
  logic [31:0]         out_tdata_r;

  logic                list_we;
  logic [LW-1:0]       list_waddr;
  logic [2*AW-1:0]     list_wdata;
  logic [LW-1:0]       list_raddr;
  logic [2*AW-1:0]     list_rdata;
  logic                mark_we;
  logic [MW-1:0]       mark_waddr;
  logic [MARK_W-1:0]   mark_wdata;
  logic [MARK_W-1:0]   mark_rdata;

  logic [AW-1:0]       rd_off;
  logic [AW-1:0]       rd_sz;
  logic [CW-1:0]       hb_calc;
  logic [CW-1:0]       cap_calc;
  logic [16:0]         rnd_req;
  logic                in_acc;
  logic [CW-1:0]       alloc_data;
  logic                merge_l;
  logic                merge_r;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign rd_off     = list_rdata[AW-1:0];
  assign rd_sz      = list_rdata[2*AW-1:AW];
  assign rnd_req    = (17'(in_tdata[15:0]) + 17'd3) & 17'h1FFFC;
  assign alloc_data = CW'(best_off_r) + CW'(HDR_BYTES);
  assign merge_l    = have_prev_r && (CW'(prev_off_r) + CW'(prev_sz_r) == hdr_r);
  assign merge_r    = have_next_r && (hdr_r + CW'(rsz_r) == CW'(next_off_r));

  always_comb begin
    hb_calc = CW'(heap_size_r);
    if (hb_calc < CW'(HEAP_FLOOR)) begin
      hb_calc = CW'(HEAP_FLOOR);
    end
    hb_calc = (hb_calc + CW'(3)) & ~CW'(3);
    if (hb_calc > CW'(MAX_HEAP_BYTES)) begin
      hb_calc = CW'(MAX_HEAP_BYTES) & ~CW'(3);
    end
    cap_calc = hb_calc >> 5;
    if (cap_calc > CW'(FREE_LIST_DEPTH)) begin
      cap_calc = CW'(FREE_LIST_DEPTH);
    end
  end

  always_comb begin
    list_we    = 1'b0;
    list_waddr = '0;
    list_wdata = list_rdata;
    list_raddr = '0;
    mark_we    = 1'b0;
    mark_waddr = mk_addr_r;
    mark_wdata = mk_data_r;
    unique case (state_r)
      S_CLEAR: begin
        list_we    = 1'b1;
        list_wdata = {heap_bytes_r, {AW{1'b0}}};
        mark_we    = 1'b1;
        mark_waddr = clr_r;
        mark_wdata = (clr_r == '0) ? {MK_FREE, MSZ_W'(heap_bytes_r)} : '0;
      end
      S_SCAN: begin
        list_raddr = sc_r[LW-1:0];
      end
      S_SHIFT: begin
        list_raddr = sh_cur_r[LW-1:0];
        list_we    = pend_r;
        list_waddr = sh_up_r ? LW'(pidx_r + CNTW'(1)) : LW'(pidx_r - CNTW'(1));
      end
      S_FIX: begin
        list_we    = fix_en_r;
        list_waddr = fix_addr_r[LW-1:0];
        list_wdata = fix_data_r;
        mark_we    = mk_en_r;
      end
      default: begin
      end
    endcase
  end

  bfha_ram #(.WIDTH(2 * AW), .DEPTH(FREE_LIST_DEPTH)) u_list (
    .clk   (clk),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (list_wdata),
    .raddr (list_raddr),
    .rdata (list_rdata)
  );

  bfha_ram #(.WIDTH(MARK_W), .DEPTH(MARK_DEPTH)) u_marks (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (hdr_r[MW+1:2]),
    .rdata (mark_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      heap_size_r  <= 15'(HEAP_FLOOR);
      heap_bytes_r <= AW'(HEAP_FLOOR);
      list_cap_r   <= CNTW'(HEAP_FLOOR / MIN_SPLIT);
      count_r      <= CNTW'(1);
      clr_r        <= '0;
      clr_reply_r  <= 1'b0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wen) begin
        heap_size_r <= cfg_wdata;
      end
      if (out_tvalid_r && out_tready && (state_r != S_REPLY)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          count_r <= CNTW'(1);
          clr_r   <= clr_r + MW'(1);
          if (clr_r == MW'(MARK_DEPTH - 1)) begin
            st_r    <= ST_OK;
            dout_r  <= '0;
            state_r <= clr_reply_r ? S_REPLY : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            st_r        <= ((in_tuser == KIND_ALLOC) && (in_tdata[15:0] == 16'd0)) ?
                           ST_BAD_SIZE : ST_OK;
            dout_r      <= '0;
            need_r      <= CW'(rnd_req) + CW'(HDR_BYTES);
            hdr_r       <= CW'(in_tdata[29:16]) - CW'(HDR_BYTES);
            rel_lo_r    <= (in_tdata[29:16] < 14'(HDR_BYTES));
            sc_r        <= '0;
            pend_r      <= 1'b0;
            found_r     <= 1'b0;
            pos_r       <= '0;
            have_prev_r <= 1'b0;
            have_next_r <= 1'b0;
            unique case (in_tuser)
              KIND_ALLOC: begin
                is_rel_r <= 1'b0;
                if (in_tdata[15:0] == 16'd0) begin
                  state_r <= S_REPLY;
                end else begin
                  state_r <= S_SCAN;
                end
              end
              KIND_RELEASE: begin
                is_rel_r <= 1'b1;
                state_r  <= S_RCHK;
              end
              KIND_REINIT: begin
                heap_bytes_r <= AW'(hb_calc);
                list_cap_r   <= CNTW'(cap_calc);
                clr_r        <= '0;
                clr_reply_r  <= 1'b1;
                state_r      <= S_CLEAR;
              end
              KIND_NONE: begin
                state_r <= S_REPLY;
              end
              default: begin
                state_r <= S_REPLY;
              end
            endcase
          end
        end
        S_RCHK: begin
          if (rel_lo_r || (hdr_r[1:0] != 2'd0) || (hdr_r >= CW'(heap_bytes_r))) begin
            st_r    <= ST_NOT_ALLOC;
            state_r <= S_REPLY;
          end else begin
            state_r <= S_MCHK;
          end
        end
        S_MCHK: begin
          rsz_r <= mark_rdata[MSZ_W-1:0];
          if (mark_rdata[MARK_W-1:MSZ_W] != MK_ALLOC) begin
            st_r    <= ST_NOT_ALLOC;
            state_r <= S_REPLY;
          end else if (count_r >= list_cap_r) begin
            st_r    <= ST_LIST_FULL;
            state_r <= S_REPLY;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (sc_r < count_r) begin
            pend_r <= 1'b1;
            pidx_r <= sc_r;
            sc_r   <= sc_r + CNTW'(1);
          end else begin
            pend_r <= 1'b0;
            if (!pend_r) begin
              state_r <= S_DECIDE;
            end
          end
          if (pend_r) begin
            if (!is_rel_r) begin
              if ((CW'(rd_sz) >= need_r) && (!found_r || (rd_sz < best_sz_r))) begin
                found_r    <= 1'b1;
                best_idx_r <= pidx_r;
                best_off_r <= rd_off;
                best_sz_r  <= rd_sz;
              end
            end else if (CW'(rd_off) < hdr_r) begin
              pos_r       <= pidx_r + CNTW'(1);
              have_prev_r <= 1'b1;
              prev_off_r  <= rd_off;
              prev_sz_r   <= rd_sz;
            end else if (!have_next_r) begin
              have_next_r <= 1'b1;
              next_off_r  <= rd_off;
              next_sz_r   <= rd_sz;
            end
          end
        end
        S_DECIDE: begin
          sh_done_r <= 1'b0;
          pend_r    <= 1'b0;
          if (!is_rel_r) begin
            mk_addr_r <= best_off_r[MW+1:2];
            if (!found_r) begin
              mk_en_r   <= 1'b0;
              fix_en_r  <= 1'b0;
              cnt_new_r <= count_r;
              dout_r    <= '0;
              st_r      <= ST_NO_FIT;
              state_r   <= S_REPLY;
            end else if (CW'(best_sz_r) < need_r + CW'(MIN_SPLIT)) begin
              mk_en_r   <= 1'b1;
              fix_en_r  <= 1'b0;
              dout_r    <= alloc_data[13:0];
              mk_data_r <= {MK_ALLOC, MSZ_W'(best_sz_r)};
              cnt_new_r <= count_r - CNTW'(1);
              sh_up_r   <= 1'b0;
              sh_cur_r  <= best_idx_r + CNTW'(1);
              sh_end_r  <= count_r - CNTW'(1);
              state_r   <= (best_idx_r + CNTW'(1) < count_r) ? S_SHIFT : S_FIX;
            end else begin
              mk_en_r    <= 1'b1;
              fix_en_r   <= 1'b1;
              dout_r     <= alloc_data[13:0];
              cnt_new_r  <= count_r;
              mk_data_r  <= {MK_ALLOC, MSZ_W'(need_r)};
              fix_addr_r <= best_idx_r;
              fix_data_r <= {AW'(CW'(best_sz_r) - need_r), AW'(CW'(best_off_r) + need_r)};
              state_r    <= S_FIX;
            end
          end else begin
            mk_en_r   <= 1'b1;
            fix_en_r  <= 1'b1;
            mk_addr_r <= hdr_r[MW+1:2];
            mk_data_r <= {MK_FREE, rsz_r};
            if (merge_l && merge_r) begin
              fix_addr_r <= pos_r - CNTW'(1);
              fix_data_r <= {AW'(CW'(prev_sz_r) + CW'(rsz_r) + CW'(next_sz_r)), prev_off_r};
              cnt_new_r  <= count_r - CNTW'(1);
              sh_up_r    <= 1'b0;
              sh_cur_r   <= pos_r + CNTW'(1);
              sh_end_r   <= count_r - CNTW'(1);
              state_r    <= (pos_r + CNTW'(1) < count_r) ? S_SHIFT : S_FIX;
            end else if (merge_l) begin
              fix_addr_r <= pos_r - CNTW'(1);
              fix_data_r <= {AW'(CW'(prev_sz_r) + CW'(rsz_r)), prev_off_r};
              cnt_new_r  <= count_r;
              state_r    <= S_FIX;
            end else if (merge_r) begin
              fix_addr_r <= pos_r;
              fix_data_r <= {AW'(CW'(rsz_r) + CW'(next_sz_r)), AW'(hdr_r)};
              cnt_new_r  <= count_r;
              state_r    <= S_FIX;
            end else begin
              fix_addr_r <= pos_r;
              fix_data_r <= {AW'(rsz_r), AW'(hdr_r)};
              cnt_new_r  <= count_r + CNTW'(1);
              sh_up_r    <= 1'b1;
              sh_cur_r   <= count_r - CNTW'(1);
              sh_end_r   <= pos_r;
              state_r    <= (pos_r < count_r) ? S_SHIFT : S_FIX;
            end
          end
        end
        S_SHIFT: begin
          if (!sh_done_r) begin
            pend_r <= 1'b1;
            pidx_r <= sh_cur_r;
            if (sh_cur_r == sh_end_r) begin
              sh_done_r <= 1'b1;
            end else if (sh_up_r) begin
              sh_cur_r <= sh_cur_r - CNTW'(1);
            end else begin
              sh_cur_r <= sh_cur_r + CNTW'(1);
            end
          end else begin
            pend_r <= 1'b0;
            if (!pend_r) begin
              state_r <= S_FIX;
            end
          end
        end
        S_FIX: begin
          count_r <= cnt_new_r;
          state_r <= S_REPLY;
        end
        S_REPLY: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {5'd0, 10'(count_r), dout_r, st_r};
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
